@@ rtl/gpd_pkg.sv @@
`timescale 1ns / 1ps

package gpd_pkg;

  // Defaults for the top-level parameters.
  localparam int POINTS_DEFAULT     = 4096;
  localparam int COORD_BITS_DEFAULT = 24;

  // Fixed field widths.
  localparam int IDX_W     = 12;
  localparam int CFG_IDX_W = 2;

  // Shift of the fixed-point reciprocal used to reduce an index modulo the store depth.
  localparam int RECIP_SHIFT = 24;

  // Item codes.
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z = 2'd2;

  // Side information that rides along with a query.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } tag_t;

endpackage

@@ rtl/gathered_point_distance_squared.sv @@
`timescale 1ns / 1ps

// A query passes the address stages, memory read, differences, squares and sum.
// One beat per cycle while out_ready is high; each stage advances whenever it is empty
// or the stage after it moves, so a stall on the result side backs up only full stages.
// Store beats write the point memory in the third stage and give no result.
// Reset clears all stage valid bits and the query point; the point memory is not cleared.
module gathered_point_distance_squared #(
  parameter int POINTS = gpd_pkg::POINTS_DEFAULT,
  parameter int COORD_BITS = gpd_pkg::COORD_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               opcode,
  input  logic [gpd_pkg::IDX_W-1:0]          point_index,
  input  logic signed [COORD_BITS-1:0]       coord_x,
  input  logic signed [COORD_BITS-1:0]       coord_y,
  input  logic signed [COORD_BITS-1:0]       coord_z,
  input  logic                               end_of_batch,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2*COORD_BITS+1:0]            distance_sq,
  output logic [gpd_pkg::IDX_W-1:0]          echo_index,
  output logic                               last,
  input  logic                               cfg_we,
  input  logic [gpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]              cfg_data
);

  import gpd_pkg::*;

  localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
  localparam int CW = 3 * COORD_BITS;

  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic signed [COORD_BITS-1:0] query_z;

  tag_t          in_tag;
  logic          a_valid;
  logic          a_ready;
  logic          a_op;
  tag_t          a_tag;
  logic [CW-1:0] a_coords;
  logic [AW-1:0] a_addr;

  logic          v3;
  logic          adv3;
  tag_t          tag3;
  logic [CW-1:0] rdata;
  logic          mem_we;
  logic          d_ready;
  tag_t          d_tag;

  // Query point registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
      query_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUERY_X: query_x <= cfg_data;
        REG_QUERY_Y: query_y <= cfg_data;
        REG_QUERY_Z: query_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_tag = '{idx: point_index, last: end_of_batch};

  // Index reduction to a store address.
  gpd_addr #(
    .POINTS     (POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_addr (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (opcode),
    .in_tag     (in_tag),
    .in_coords  ({coord_x, coord_y, coord_z}),
    .out_valid  (a_valid),
    .out_ready  (a_ready),
    .out_op     (a_op),
    .out_tag    (a_tag),
    .out_coords (a_coords),
    .out_addr   (a_addr)
  );

  // Memory stage: stores write here and end, queries read and move on.
  assign adv3    = !v3 || d_ready;
  assign a_ready = adv3;
  assign mem_we  = a_valid && adv3 && (a_op == OP_STORE);

  gpd_ram #(
    .WIDTH (CW),
    .DEPTH (POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (adv3),
    .addr  (a_addr),
    .wdata (a_coords),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= a_valid && (a_op == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      tag3 <= a_tag;
    end
  end

  // Differences, squares and sum.
  gpd_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_ready  (d_ready),
    .in_tag    (tag3),
    .in_coords (rdata),
    .query_x   (query_x),
    .query_y   (query_y),
    .query_z   (query_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tag   (d_tag),
    .out_sumsq (distance_sq)
  );

  assign echo_index = d_tag.idx;
  assign last       = d_tag.last;

  // Back-pressure on the input can only come from a result that is waiting.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a waiting result");

endmodule

@@ rtl/gpd_ram.sv @@
`timescale 1ns / 1ps

module gpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port: write on we, registered read held while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/gpd_addr.sv @@
`timescale 1ns / 1ps

module gpd_addr #(
  parameter int POINTS = gpd_pkg::POINTS_DEFAULT,
  parameter int COORD_BITS = gpd_pkg::COORD_BITS_DEFAULT,
  localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  gpd_pkg::tag_t             in_tag,
  input  logic [3*COORD_BITS-1:0]   in_coords,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_op,
  output gpd_pkg::tag_t             out_tag,
  output logic [3*COORD_BITS-1:0]   out_coords,
  output logic [AW-1:0]             out_addr
);

  import gpd_pkg::*;

  localparam int          PRODW = IDX_W + RECIP_SHIFT;
  localparam int          MW    = IDX_W + AW + 1;
  localparam longint      RECIP = (64'd1 << RECIP_SHIFT) / POINTS;

  // Stage one: captured beat.
  logic                    v1;
  logic                    op1;
  tag_t                    tag1;
  logic [3*COORD_BITS-1:0] coords1;
  // Stage two: quotient estimate.
  logic                    v2;
  logic                    op2;
  tag_t                    tag2;
  logic [3*COORD_BITS-1:0] coords2;
  logic [IDX_W-1:0]        quot2;

  logic            adv1;
  logic            adv2;
  logic [PRODW-1:0] prod;
  logic [MW-1:0]    qp;
  logic [MW-1:0]    rem;
  logic [MW-1:0]    rem_fix;

  assign adv2     = !v2 || out_ready;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  // The floor reciprocal can give a quotient one too small, never too large.
  assign prod = PRODW'(tag1.idx) * PRODW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      op1     <= in_op;
      tag1    <= in_tag;
      coords1 <= in_coords;
    end
    if (adv2) begin
      op2     <= op1;
      tag2    <= tag1;
      coords2 <= coords1;
      quot2   <= prod[PRODW-1:RECIP_SHIFT];
    end
  end

  // Remainder from the estimate, then one corrective subtract.
  assign qp      = MW'(quot2) * MW'(POINTS);
  assign rem     = MW'(tag2.idx) - qp;
  assign rem_fix = (rem >= MW'(POINTS)) ? (rem - MW'(POINTS)) : rem;

  assign out_valid  = v2;
  assign out_op     = op2;
  assign out_tag    = tag2;
  assign out_coords = coords2;
  assign out_addr   = rem_fix[AW-1:0];

  // The raw remainder never reaches twice the depth, and the address stays in range.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (rem < (MW'(POINTS) << 1)))
    else $error("index remainder out of range");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (rem_fix < MW'(POINTS)))
    else $error("store address beyond depth");

endmodule

@@ rtl/gpd_dist.sv @@
`timescale 1ns / 1ps

module gpd_dist #(
  parameter int COORD_BITS = gpd_pkg::COORD_BITS_DEFAULT,
  localparam int DW = 2 * COORD_BITS + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gpd_pkg::tag_t                 in_tag,
  input  logic [3*COORD_BITS-1:0]       in_coords,
  input  logic signed [COORD_BITS-1:0]  query_x,
  input  logic signed [COORD_BITS-1:0]  query_y,
  input  logic signed [COORD_BITS-1:0]  query_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gpd_pkg::tag_t                 out_tag,
  output logic [DW-1:0]                 out_sumsq
);

  import gpd_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int SW = 2 * CB + 1;

  logic                   v4;
  logic                   v5;
  logic                   v6;
  logic                   adv4;
  logic                   adv5;
  logic                   adv6;
  tag_t                   tag4;
  tag_t                   tag5;
  tag_t                   tag6;
  logic signed [CB:0]     dx;
  logic signed [CB:0]     dy;
  logic signed [CB:0]     dz;
  logic [SW-1:0]          sqx;
  logic [SW-1:0]          sqy;
  logic [SW-1:0]          sqz;
  logic [DW-1:0]          sum_sq;
  logic [CB-1:0]          px;
  logic [CB-1:0]          py;
  logic [CB-1:0]          pz;
  logic signed [2*CB+1:0] mx;
  logic signed [2*CB+1:0] my;
  logic signed [2*CB+1:0] mz;

  assign adv6     = !v6 || out_ready;
  assign adv5     = !v5 || adv6;
  assign adv4     = !v4 || adv5;
  assign in_ready = adv4;

  assign px = in_coords[3*CB-1:2*CB];
  assign py = in_coords[2*CB-1:CB];
  assign pz = in_coords[CB-1:0];

  // Full products of the registered differences; the square fits in SW bits.
  assign mx = dx * dx;
  assign my = dy * dy;
  assign mz = dz * dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (adv4) begin
        v4 <= in_valid;
      end
      if (adv5) begin
        v5 <= v4;
      end
      if (adv6) begin
        v6 <= v5;
      end
    end
  end

  // Differences, then squares, then the sum, one register stage each.
  always_ff @(posedge clk) begin
    if (adv4) begin
      tag4 <= in_tag;
      dx   <= $signed({px[CB-1], px}) - $signed({query_x[CB-1], query_x});
      dy   <= $signed({py[CB-1], py}) - $signed({query_y[CB-1], query_y});
      dz   <= $signed({pz[CB-1], pz}) - $signed({query_z[CB-1], query_z});
    end
    if (adv5) begin
      tag5 <= tag4;
      sqx  <= mx[SW-1:0];
      sqy  <= my[SW-1:0];
      sqz  <= mz[SW-1:0];
    end
    if (adv6) begin
      tag6   <= tag5;
      sum_sq <= DW'(sqx) + DW'(sqy) + DW'(sqz);
    end
  end

  assign out_valid = v6;
  assign out_tag   = tag6;
  assign out_sumsq = sum_sq;

  // No squared difference can exceed the square of the full coordinate span.
  a_square_bound: assert property (@(posedge clk) disable iff (rst)
    v5 |-> (sqx <= (SW'(1) << (2 * CB))) && (sqy <= (SW'(1) << (2 * CB)))
           && (sqz <= (SW'(1) << (2 * CB))))
    else $error("squared difference out of range");

endmodule
